// File: rtl/jmsc_pkg.sv
// Package for the JPEG marker structure checker: verdict codes, marker codes and helpers.
package jmsc_pkg;

    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_NO_SOI   = 3'd1;
    localparam logic [2:0] VERDICT_TRUNC    = 3'd2;
    localparam logic [2:0] VERDICT_TOO_LONG = 3'd3;
    localparam logic [2:0] VERDICT_NO_EOI   = 3'd4;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_STUF = 8'h00;
    localparam logic [7:0] MRK_SOI   = 8'hD8;
    localparam logic [7:0] MRK_EOI   = 8'hD9;
    localparam logic [7:0] MRK_SOS   = 8'hDA;
    localparam logic [7:0] MRK_TEM   = 8'h01;
    localparam logic [7:0] MRK_LEN_LO = 8'hC0;
    localparam logic [7:0] MRK_LEN_HI = 8'hFE;

    // Bytes counted before a file counts as long enough.
    localparam logic [2:0] MIN_FILE_BYTES = 3'd4;

    // Result of one byte step: whether a verdict is given, and its code.
    typedef struct packed {
        logic       valid;
        logic [2:0] verdict;
    } result_t;

    // True for the restart markers RST0 through RST7.
    function automatic logic is_rst(input logic [7:0] m);
        is_rst = (m[7:3] == 5'b11010);
    endfunction

    // True for marker codes that are followed by a two-byte length.
    function automatic logic has_length(input logic [7:0] m);
        has_length = (m == MRK_TEM) ||
                     ((m >= MRK_LEN_LO) && (m <= MRK_LEN_HI) && !is_rst(m));
    endfunction

endpackage

// File: rtl/jmsc_core.sv
// Marker parsing state machine: updates the file state by one byte per accepted item.
module jmsc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                is_last,
    output jmsc_pkg::result_t   result
);

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_EXPECT_FF,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_SCAN,
        PH_DONE_OK,
        PH_BAD_SOI,
        PH_NO_EOI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bytes_seen_reg, bytes_seen_next;
    logic [15:0] seg_rem_reg, seg_rem_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        seg_scan_reg, seg_scan_next;
    logic        in_scan_reg, in_scan_next;

    logic [15:0] seg_len;
    logic [15:0] seg_dec;
    logic [2:0]  verdict;

    assign seg_len = {len_hi_reg, data_byte};
    assign seg_dec = (seg_rem_reg != 16'd0) ? (seg_rem_reg - 16'd1) : 16'd0;

    always_comb begin
        phase_next      = phase_reg;
        seg_rem_next    = seg_rem_reg;
        len_hi_next     = len_hi_reg;
        seg_scan_next   = seg_scan_reg;
        in_scan_next    = in_scan_reg;
        bytes_seen_next = (bytes_seen_reg < jmsc_pkg::MIN_FILE_BYTES) ?
                          (bytes_seen_reg + 3'd1) : bytes_seen_reg;
        verdict         = jmsc_pkg::VERDICT_NO_EOI;

        unique case (phase_reg)
            PH_SOI0: begin
                phase_next = (data_byte == jmsc_pkg::BYTE_FF) ? PH_SOI1 : PH_BAD_SOI;
                verdict    = jmsc_pkg::VERDICT_NO_SOI;
            end
            PH_SOI1: begin
                phase_next = (data_byte == jmsc_pkg::MRK_SOI) ? PH_EXPECT_FF : PH_BAD_SOI;
                verdict    = jmsc_pkg::VERDICT_NO_SOI;
            end
            PH_EXPECT_FF: begin
                phase_next = (data_byte == jmsc_pkg::BYTE_FF) ? PH_MARKER : PH_NO_EOI;
            end
            PH_MARKER: begin
                priority if (data_byte == jmsc_pkg::BYTE_STUF) begin
                    phase_next = in_scan_reg ? PH_SCAN : PH_EXPECT_FF;
                end else if (data_byte == jmsc_pkg::MRK_EOI) begin
                    phase_next = PH_DONE_OK;
                    verdict    = jmsc_pkg::VERDICT_OK;
                end else if (jmsc_pkg::has_length(data_byte)) begin
                    seg_scan_next = (data_byte == jmsc_pkg::MRK_SOS);
                    in_scan_next  = 1'b0;
                    phase_next    = PH_LEN_HI;
                    verdict       = jmsc_pkg::VERDICT_TRUNC;
                end else if (in_scan_reg && jmsc_pkg::is_rst(data_byte)) begin
                    phase_next = PH_SCAN;
                end else begin
                    in_scan_next = 1'b0;
                    phase_next   = PH_EXPECT_FF;
                end
            end
            PH_LEN_HI: begin
                len_hi_next = data_byte;
                phase_next  = PH_LEN_LO;
                verdict     = jmsc_pkg::VERDICT_TRUNC;
            end
            PH_LEN_LO: begin
                seg_rem_next = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;
                if (seg_rem_next != 16'd0) begin
                    phase_next = PH_SKIP;
                    verdict    = jmsc_pkg::VERDICT_TOO_LONG;
                end else begin
                    phase_next    = seg_scan_reg ? PH_SCAN : PH_EXPECT_FF;
                    in_scan_next  = seg_scan_reg ? 1'b1 : in_scan_reg;
                    seg_scan_next = 1'b0;
                end
            end
            PH_SKIP: begin
                seg_rem_next = seg_dec;
                if (seg_dec != 16'd0) begin
                    verdict = jmsc_pkg::VERDICT_TOO_LONG;
                end else begin
                    phase_next    = seg_scan_reg ? PH_SCAN : PH_EXPECT_FF;
                    in_scan_next  = seg_scan_reg ? 1'b1 : in_scan_reg;
                    seg_scan_next = 1'b0;
                end
            end
            PH_SCAN: begin
                if (data_byte == jmsc_pkg::BYTE_FF) begin
                    phase_next = PH_MARKER;
                end
            end
            PH_DONE_OK: begin
                verdict = jmsc_pkg::VERDICT_OK;
            end
            PH_BAD_SOI: begin
                verdict = jmsc_pkg::VERDICT_NO_SOI;
            end
            default: begin
                phase_next = PH_NO_EOI;
            end
        endcase

        // A short file overrides every other verdict.
        result.valid   = is_last;
        result.verdict = (bytes_seen_next < jmsc_pkg::MIN_FILE_BYTES) ?
                         jmsc_pkg::VERDICT_NO_SOI : verdict;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SOI0;
            bytes_seen_reg <= 3'd0;
            seg_rem_reg    <= 16'd0;
            len_hi_reg     <= 8'd0;
            seg_scan_reg   <= 1'b0;
            in_scan_reg    <= 1'b0;
        end else if (step) begin
            if (is_last) begin
                // The verdict closes the file; the next byte opens a new one.
                phase_reg      <= PH_SOI0;
                bytes_seen_reg <= 3'd0;
                seg_rem_reg    <= 16'd0;
                len_hi_reg     <= 8'd0;
                seg_scan_reg   <= 1'b0;
                in_scan_reg    <= 1'b0;
            end else begin
                phase_reg      <= phase_next;
                bytes_seen_reg <= bytes_seen_next;
                seg_rem_reg    <= seg_rem_next;
                len_hi_reg     <= len_hi_next;
                seg_scan_reg   <= seg_scan_next;
                in_scan_reg    <= in_scan_next;
            end
        end
    end

endmodule

// File: rtl/jpeg_marker_structure_checker_top.sv
// Top level of the JPEG marker structure checker: input register, parser and result register.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_data_byte[7:0], s_is_last
//   m_        out        m_valid / m_ready   m_verdict[2:0]
//
// Each item is one byte of a file. One byte is accepted in every cycle while
// s_ready is high; an accepted byte is held in the input register and parsed
// when it advances, and its verdict, if it is the last byte of a file, is
// registered in the result register and then shown on m_.
// The parser state update takes one step per advance, which sets the rate at one
// byte per clock while no last byte is held back. While a verdict waits on m_ with m_ready low, the input
// register still drains bytes that give no verdict; a last byte waits in the
// input register until the verdict slot is free. Reset (aresetn low, sampled
// on aclk) empties both registers and returns the parser to the start of a file.
module jpeg_marker_structure_checker_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_verdict
);

    // Input register: holds one accepted byte for the parser.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register: holds one verdict until it is taken.
    logic       out_valid_reg;
    logic [2:0] out_verdict_reg;

    logic              advance;
    jmsc_pkg::result_t step_result;

    // The held byte moves on unless it carries a verdict and the slot is full with m_ready low.
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    jmsc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && step_result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_is_last;
        end
        if (advance && step_result.valid) begin
            out_verdict_reg <= step_result.verdict;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = out_verdict_reg;

endmodule

// File: rtl/jmsc_checker.sv
// Port-level assertions for the JPEG marker structure checker, bound to the top level.
module jmsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_is_last,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_verdict
);

    // A stalled verdict holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict))
        else $error("verdict changed while stalled");

    // Only the five defined verdict codes appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_verdict <= jmsc_pkg::VERDICT_NO_EOI)
        else $error("undefined verdict code");

    // Reset leaves no verdict pending and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state not cleared by reset");

    // A newly raised verdict must follow the acceptance of a last byte or a stall on s_ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_is_last, 2) ||
                           $past(!s_ready, 1))
        else $error("verdict without a last byte");

endmodule

bind jpeg_marker_structure_checker_top jmsc_checker u_jmsc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_is_last   (s_is_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_verdict   (m_verdict)
);
